FILE: design/stwa_pkg.sv
// Shared types and constants for the session table with entry aging.
// No dependencies; every other design file refers to this package by scoped names.
package stwa_pkg;

  localparam int unsigned KeyW      = 64;
  localparam int unsigned LifeW     = 32;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned CountOutW = 7;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [CfgW-1:0] LimitReset = 7'd64;

  // register index taken from paddr[2]
  localparam logic RegSessionLimit = 1'b0;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_VERIFY = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key_high;
    logic [KeyW-1:0]  key_low;
    logic [LifeW-1:0] reload;
    logic [LifeW-1:0] left;
  } entry_t;

endpackage

FILE: design/stwa_cell.sv
// One cell of the rotating entry ring: holds a single session entry.
// Depends on stwa_pkg for the entry type.
module stwa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  stwa_pkg::entry_t entry_i,
  output stwa_pkg::entry_t entry_o
);

  logic                      valid_q;
  logic [stwa_pkg::KeyW-1:0]  key_high_q;
  logic [stwa_pkg::KeyW-1:0]  key_low_q;
  logic [stwa_pkg::LifeW-1:0] reload_q;
  logic [stwa_pkg::LifeW-1:0] left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_high_q <= entry_i.key_high;
      key_low_q  <= entry_i.key_low;
      reload_q   <= entry_i.reload;
      left_q     <= entry_i.left;
    end
  end

  assign entry_o = '{valid: valid_q, key_high: key_high_q, key_low: key_low_q,
                     reload: reload_q, left: left_q};

endmodule

FILE: design/stwa_ctrl.sv
// Sequencer and head-of-ring processing for the session table.
// Depends on stwa_pkg; works on the entry leaving cell 0 and feeds the last cell.
module stwa_ctrl #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  stwa_pkg::action_e              action_i,
  input  logic [stwa_pkg::KeyW-1:0]      token_high_i,
  input  logic [stwa_pkg::KeyW-1:0]      token_low_i,
  input  logic [stwa_pkg::LifeW-1:0]     lifetime_i,
  input  logic [stwa_pkg::CfgW-1:0]      limit_i,
  input  stwa_pkg::entry_t               head_i,
  output stwa_pkg::entry_t               tail_o,
  output logic                           shift_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output stwa_pkg::status_e              status_o,
  output logic [stwa_pkg::CountOutW-1:0] entry_count_o
);

  localparam int unsigned CntW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CountW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW   = (CountW > stwa_pkg::CfgW) ? CountW : stwa_pkg::CfgW;
  localparam logic [CntW-1:0]   LastIdx  = CntW'(MAX_ENTRIES - 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MAX_ENTRIES);

  stwa_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              pass_q, pass_d;
  logic              hit_q, hit_d;
  logic              pend_q, pend_d;
  stwa_pkg::status_e status_q, status_d;
  logic [CountW-1:0] count_q, count_d;
  logic              m_valid_q, m_valid_d;
  stwa_pkg::status_e m_status_q, m_status_d;
  logic [stwa_pkg::CountOutW-1:0] m_count_q, m_count_d;

  stwa_pkg::action_e          act_q;
  logic [stwa_pkg::KeyW-1:0]  key_high_q;
  logic [stwa_pkg::KeyW-1:0]  key_low_q;
  logic [stwa_pkg::LifeW-1:0] life_q;

  logic                       match;
  logic                       full;
  logic [stwa_pkg::LifeW-1:0] life_dec;
  logic                       accept;

  assign match = head_i.valid && (head_i.key_high == key_high_q)
                 && (head_i.key_low == key_low_q);
  assign full  = (CmpW'(count_q) >= CmpW'(limit_i)) || (count_q == CountMax);
  assign life_dec = (head_i.left == '0) ? '0 : head_i.left - 1'b1;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stwa_pkg::S_IDLE;
      idx_q     <= '0;
      pass_q    <= 1'b0;
      hit_q     <= 1'b0;
      pend_q    <= 1'b0;
      status_q  <= stwa_pkg::ST_OK;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pass_q    <= pass_d;
      hit_q     <= hit_d;
      pend_q    <= pend_d;
      status_q  <= status_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_status_q <= m_status_d;
    m_count_q  <= m_count_d;
    if (accept) begin
      act_q      <= action_i;
      key_high_q <= token_high_i;
      key_low_q  <= token_low_i;
      life_q     <= lifetime_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    hit_d      = hit_q;
    pend_d     = pend_q;
    status_d   = status_q;
    count_d    = count_q;
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_count_d  = m_count_q;
    tail_o     = head_i;
    shift_o    = 1'b0;
    in_ready_o = 1'b0;

    if (out_ready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      stwa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = stwa_pkg::S_SCAN;
          idx_d   = '0;
          pass_d  = 1'b0;
          hit_d   = 1'b0;
          pend_d  = 1'b0;
        end
      end
      stwa_pkg::S_SCAN: begin
        shift_o = 1'b1;
        idx_d   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
        if (!pass_q) begin
          unique case (act_q)
            stwa_pkg::ACT_ADD: begin
              if (match) begin
                hit_d = 1'b1;
              end
            end
            stwa_pkg::ACT_DELETE: begin
              if (match) begin
                tail_o.valid = 1'b0;
                count_d      = count_q - 1'b1;
              end
            end
            stwa_pkg::ACT_VERIFY: begin
              if (match) begin
                tail_o.left = head_i.reload;
                hit_d       = 1'b1;
              end
            end
            stwa_pkg::ACT_TICK: begin
              if (head_i.valid) begin
                tail_o.left = life_dec;
                if (life_dec == '0) begin
                  tail_o.valid = 1'b0;
                  count_d      = count_q - 1'b1;
                end
              end
            end
          endcase
          if (idx_q == LastIdx) begin
            unique case (act_q)
              stwa_pkg::ACT_ADD: begin
                if (hit_d || full) begin
                  status_d = stwa_pkg::ST_REJECTED;
                  state_d  = stwa_pkg::S_DONE;
                end else begin
                  status_d = stwa_pkg::ST_OK;
                  pass_d   = 1'b1;
                  pend_d   = 1'b1;
                end
              end
              stwa_pkg::ACT_VERIFY: begin
                status_d = hit_d ? stwa_pkg::ST_OK : stwa_pkg::ST_NOT_FOUND;
                state_d  = stwa_pkg::S_DONE;
              end
              default: begin
                status_d = stwa_pkg::ST_OK;
                state_d  = stwa_pkg::S_DONE;
              end
            endcase
          end
        end else begin
          if (pend_q && !head_i.valid) begin
            tail_o  = '{valid: 1'b1, key_high: key_high_q, key_low: key_low_q,
                        reload: life_q, left: life_q};
            count_d = count_q + 1'b1;
            pend_d  = 1'b0;
          end
          if (idx_q == LastIdx) begin
            state_d = stwa_pkg::S_DONE;
          end
        end
      end
      stwa_pkg::S_DONE: begin
        if (!m_valid_q || out_ready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_count_d  = stwa_pkg::CountOutW'(count_q);
          state_d    = stwa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stwa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = m_valid_q;
  assign status_o      = m_status_q;
  assign entry_count_o = m_count_q;

endmodule

FILE: design/session_table_with_aging_top.sv
// Top level of the session table with entry aging: ring of entry cells, sequencer, APB register.
// Depends on stwa_pkg, stwa_cell and stwa_ctrl.
// Each transaction takes one full turn of the entry ring through the single compare and update
// unit at its head; an add that passes its checks takes a second turn to place the new entry.
// A new transaction is accepted only once the previous one has finished its turns.
// A result held at the output does not block acceptance of the next transaction.
// Reset clears all entries, the live count and the sequencer; session_limit resets to 64.
module session_table_with_aging_top #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [159:0]                    s_axis_tdata,  // token_high, token_low, lifetime
  input  logic [1:0]                      s_axis_tuser,  // action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // status, entry_count, zero fill
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stwa_pkg::ApbAddrW-1:0]   paddr,
  input  logic [stwa_pkg::ApbDataW-1:0]   pwdata,
  output logic [stwa_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  logic [stwa_pkg::CfgW-1:0] limit_q;
  stwa_pkg::entry_t          cell_out [MAX_ENTRIES];
  stwa_pkg::entry_t          tail;
  logic                      shift;
  stwa_pkg::status_e         status;
  logic [stwa_pkg::CountOutW-1:0] entry_count;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= stwa_pkg::LimitReset;
    end else if (psel && penable && pwrite && (paddr[2] == stwa_pkg::RegSessionLimit)) begin
      limit_q <= pwdata[stwa_pkg::CfgW-1:0];
    end
  end

  assign prdata = (paddr[2] == stwa_pkg::RegSessionLimit)
                  ? stwa_pkg::ApbDataW'(limit_q) : '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_ring
    stwa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i ((k == MAX_ENTRIES - 1) ? tail : cell_out[(k + 1) % MAX_ENTRIES]),
      .entry_o (cell_out[k])
    );
  end

  stwa_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (stwa_pkg::action_e'(s_axis_tuser)),
    .token_high_i  (s_axis_tdata[63:0]),
    .token_low_i   (s_axis_tdata[127:64]),
    .lifetime_i    (s_axis_tdata[159:128]),
    .limit_i       (limit_q),
    .head_i        (cell_out[0]),
    .tail_o        (tail),
    .shift_o       (shift),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {7'b0, entry_count, status};

endmodule
